// ===== src/ppid_pkg.sv =====
// Shared widths, register indexes and saturation helpers for the PID controller.
package ppid_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;               // gains, setpoint, sample, error
  localparam int ERR_W  = 32;
  localparam int INT_W  = 28;               // integral accumulator
  localparam int OUT_W  = 27;               // control output
  localparam int LIM_W  = 10;               // limits in whole units
  localparam int ACC_W  = ERR_W + 1;        // one bit of headroom for add/sub
  localparam int SHL_W  = LIM_W + FRAC_BITS;
  localparam int FIT_W  = (SHL_W > INT_W) ? SHL_W : INT_W;
  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;       // exact sum of three terms

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INT_LIM  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_LIM  = 3'd5;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1000);

  // Saturate a value with one guard bit down to ERR_W bits.
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] x);
    logic signed [ERR_W-1:0] r;
    if (x[ACC_W-1] != x[ACC_W-2]) begin
      r = x[ACC_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      r = x[ERR_W-1:0];
    end
    return r;
  endfunction

  // Whole-unit limit moved to fixed point, capped at the largest positive
  // value of a w-bit signed quantity.
  function automatic logic [FIT_W-1:0] limit_fit(input logic [LIM_W-1:0] whole,
                                                  input int unsigned w);
    logic [FIT_W-1:0] v;
    logic [FIT_W-1:0] cap;
    v   = FIT_W'({whole, {FRAC_BITS{1'b0}}});
    cap = {FIT_W{1'b1}} >> (FIT_W - w + 1);
    return (v > cap) ? cap : v;
  endfunction

endpackage

// ===== src/ppid_state.sv =====
// Error, clamped integral and error change; holds the controller state.
module ppid_state import ppid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] setpoint,
  input  logic [LIM_W-1:0]         integral_limit,
  input  logic signed [DATA_W-1:0] meas,
  output logic signed [ERR_W-1:0]  err,
  output logic signed [INT_W-1:0]  integ,
  output logic signed [ERR_W-1:0]  derr
);

  logic signed [ERR_W-1:0] previous_error;
  logic signed [INT_W-1:0] integral_sum;

  logic signed [ERR_W-1:0] err_next;
  logic signed [INT_W-1:0] integ_next;
  logic signed [ERR_W-1:0] derr_next;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] ilim;
  logic [FIT_W-1:0]        ilim_fit;

  always_comb begin
    err_next  = sat_err(ACC_W'(setpoint) - ACC_W'(meas));
    ilim_fit  = limit_fit(integral_limit, INT_W);
    ilim      = $signed(ACC_W'(ilim_fit[INT_W-1:0]));
    acc       = ACC_W'(integral_sum) + ACC_W'(err_next);
    if (acc > ilim) begin
      integ_next = ilim[INT_W-1:0];
    end else if (acc < -ilim) begin
      integ_next = INT_W'(-ilim);
    end else begin
      integ_next = acc[INT_W-1:0];
    end
    derr_next = sat_err(ACC_W'(err_next) - ACC_W'(previous_error));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (load) begin
      previous_error <= err_next;
      integral_sum   <= integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err   <= err_next;
      integ <= integ_next;
      derr  <= derr_next;
    end
  end

endmodule

// ===== src/ppid_mult.sv =====
// Three gain products, floored back to the fixed-point scale and registered.
module ppid_mult import ppid_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] gain_proportional,
  input  logic signed [DATA_W-1:0] gain_integral,
  input  logic signed [DATA_W-1:0] gain_derivative,
  input  logic signed [ERR_W-1:0]  err,
  input  logic signed [INT_W-1:0]  integ,
  input  logic signed [ERR_W-1:0]  derr,
  output logic signed [TERM_W-1:0] term_p,
  output logic signed [TERM_W-1:0] term_i,
  output logic signed [TERM_W-1:0] term_d
);

  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_p = PROD_W'(gain_proportional) * PROD_W'(err);
  assign prod_i = PROD_W'(gain_integral) * PROD_W'(integ);
  assign prod_d = PROD_W'(gain_derivative) * PROD_W'(derr);

  // dropping the low bits is an arithmetic shift, i.e. a floor
  always_ff @(posedge clk) begin
    if (load) begin
      term_p <= prod_p[PROD_W-1:FRAC_BITS];
      term_i <= prod_i[PROD_W-1:FRAC_BITS];
      term_d <= prod_d[PROD_W-1:FRAC_BITS];
    end
  end

endmodule

// ===== src/ppid_out.sv =====
// Term sum, output clamp and the result register.
module ppid_out import ppid_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic [LIM_W-1:0]         output_limit,
  input  logic signed [TERM_W-1:0] term_p,
  input  logic signed [TERM_W-1:0] term_i,
  input  logic signed [TERM_W-1:0] term_d,
  output logic signed [OUT_W-1:0]  control_output,
  output logic                     output_clamped
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] olim;
  logic [FIT_W-1:0]        olim_fit;
  logic signed [OUT_W-1:0] co_next;
  logic                    clamped_next;

  always_comb begin
    sum      = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
    olim_fit = limit_fit(output_limit, OUT_W);
    olim     = $signed(SUM_W'(olim_fit[OUT_W-1:0]));
    if (sum > olim) begin
      co_next      = olim[OUT_W-1:0];
      clamped_next = 1'b1;
    end else if (sum < -olim) begin
      co_next      = OUT_W'(-olim);
      clamped_next = 1'b1;
    end else begin
      co_next      = sum[OUT_W-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      control_output <= co_next;
      output_clamped <= clamped_next;
    end
  end

endmodule

// ===== src/positional_pid_controller_top.sv =====
// Stages: sample register, error/integral stage, product stage and result register.
// Throughput: one sample per cycle; sample register, error/integral stage,
//   product stage and result register each hold one request. Intake stalls only
//   once all four hold a request and the result is stalled.
// Reset (rst, synchronous): pipeline emptied, state zeroed, gains and setpoint
//   zero, both limits 1000 whole units; the integral and previous error update
//   once per accepted sample in the error stage.
module positional_pid_controller_top import ppid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // sample request
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] measured_value,
  // result request
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  control_output,
  output logic                     output_clamped
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] gain_proportional;
  logic signed [DATA_W-1:0] gain_integral;
  logic signed [DATA_W-1:0] gain_derivative;
  logic signed [DATA_W-1:0] setpoint;
  logic [LIM_W-1:0]         integral_limit;
  logic [LIM_W-1:0]         output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
      setpoint          <= '0;
      integral_limit    <= LIM_RESET;
      output_limit      <= LIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_P:   gain_proportional <= cfg_data;
        REG_GAIN_I:   gain_integral     <= cfg_data;
        REG_GAIN_D:   gain_derivative   <= cfg_data;
        REG_SETPOINT: setpoint          <= cfg_data;
        REG_INT_LIM:  integral_limit    <= cfg_data[LIM_W-1:0];
        REG_OUT_LIM:  output_limit      <= cfg_data[LIM_W-1:0];
        default: ;   // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline occupancy. Each stage moves on when the one after it is empty or
  // moving, so bubbles close up and a waiting result blocks intake only once
  // every stage is full.
  // ---------------------------------------------------------------------------
  logic v_in, v_err, v_prod;
  logic rdy_out, rdy_prod, rdy_err, rdy_in;
  logic accept;

  assign rdy_out  = !out_valid || !out_stall;
  assign rdy_prod = !v_prod || rdy_out;
  assign rdy_err  = !v_err || rdy_prod;
  assign rdy_in   = !v_in || rdy_err;
  assign in_stall = !rdy_in;
  assign accept   = in_valid && rdy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      v_err     <= 1'b0;
      v_prod    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_in)   v_in      <= in_valid;
      if (rdy_err)  v_err     <= v_in;
      if (rdy_prod) v_prod    <= v_err;
      if (rdy_out)  out_valid <= v_prod;
    end
  end

  // sample register
  logic signed [DATA_W-1:0] meas;

  always_ff @(posedge clk) begin
    if (accept) begin
      meas <= measured_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  err;
  logic signed [INT_W-1:0]  integ;
  logic signed [ERR_W-1:0]  derr;
  logic signed [TERM_W-1:0] term_p, term_i, term_d;

  // error stage: also commits integral and previous error for the next sample
  ppid_state u_state (
    .clk            (clk),
    .rst            (rst),
    .load           (v_in && rdy_err),
    .setpoint       (setpoint),
    .integral_limit (integral_limit),
    .meas           (meas),
    .err            (err),
    .integ          (integ),
    .derr           (derr)
  );

  ppid_mult u_mult (
    .clk               (clk),
    .load              (v_err && rdy_prod),
    .gain_proportional (gain_proportional),
    .gain_integral     (gain_integral),
    .gain_derivative   (gain_derivative),
    .err               (err),
    .integ             (integ),
    .derr              (derr),
    .term_p            (term_p),
    .term_i            (term_i),
    .term_d            (term_d)
  );

  ppid_out u_out (
    .clk            (clk),
    .load           (v_prod && rdy_out),
    .output_limit   (output_limit),
    .term_p         (term_p),
    .term_i         (term_i),
    .term_d         (term_d),
    .control_output (control_output),
    .output_clamped (output_clamped)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the positional PID controller: predicted drive values against the RTL.
module testbench import ppid_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Result register is the fourth stage, counting the sample register.
  localparam int PIPE_LATENCY = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 125;
  localparam int HOLD_OFF_CYCLES = 60;

  // Indexes with no register behind them; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [DATA_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] FIX_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] FIX_ONE = 32'h0001_0000;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic                    clamped;
  } drive_t;

  // Tracks the controller state alongside the RTL and holds the drive values still owed.
  class drive_scoreboard;
    localparam longint ERR_HI = 64'sd2147483647;
    localparam longint ERR_LO = -64'sd2147483648;

    drive_t      drive_due[$];
    longint      kp, ki, kd, target;
    int unsigned int_lim_units, out_lim_units;
    longint      last_error, integ_sum;
    int          failures, checked, clamp_count, samples;

    function new();
      kp = 0; ki = 0; kd = 0; target = 0;
      int_lim_units = 1000; out_lim_units = 1000;
      last_error = 0; integ_sum = 0;
      failures = 0; checked = 0; clamp_count = 0; samples = 0;
    endfunction

    function void configure(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:   kp = longint'(signed'(data));
        REG_GAIN_I:   ki = longint'(signed'(data));
        REG_GAIN_D:   kd = longint'(signed'(data));
        REG_SETPOINT: target = longint'(signed'(data));
        REG_INT_LIM:  int_lim_units = data[LIM_W-1:0];
        REG_OUT_LIM:  out_lim_units = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    // Whole units to fixed point, capped at the largest w-bit signed value.
    function longint fixed_limit(int unsigned units, int w);
      longint v;
      longint cap;
      v   = longint'(units) <<< FRAC_BITS;
      cap = (64'sd1 <<< (w - 1)) - 1;
      return (v > cap) ? cap : v;
    endfunction

    function void take_sample(logic signed [DATA_W-1:0] meas);
      longint err, derr, integ, ilim, olim, total, drive;
      drive_t d;
      err   = clip(target - longint'(meas), ERR_LO, ERR_HI);
      ilim  = fixed_limit(int_lim_units, INT_W);
      olim  = fixed_limit(out_lim_units, OUT_W);
      integ = clip(integ_sum + err, -ilim, ilim);
      derr  = clip(err - last_error, ERR_LO, ERR_HI);
      // arithmetic shifts floor toward minus infinity
      total = ((kp * err) >>> FRAC_BITS) + ((ki * integ) >>> FRAC_BITS)
            + ((kd * derr) >>> FRAC_BITS);
      drive = clip(total, -olim, olim);
      integ_sum  = integ;
      last_error = err;
      d.drive   = drive[OUT_W-1:0];
      d.clamped = (drive != total);
      drive_due.push_back(d);
      samples++;
    endfunction

    function void check_drive(logic signed [OUT_W-1:0] drive, logic clamped);
      drive_t d;
      if (drive_due.size() == 0) begin
        $display("%0t unexpected result: drive %0d clamped %0b", $time, drive, clamped);
        failures++;
        return;
      end
      d = drive_due.pop_front();
      checked++;
      if (d.clamped) clamp_count++;
      if (drive !== d.drive) begin
        $display("%0t control_output mismatch: expected %0d actual %0d",
                 $time, d.drive, drive);
        failures++;
      end
      if (clamped !== d.clamped) begin
        $display("%0t output_clamped mismatch: expected %0b actual %0b",
                 $time, d.clamped, clamped);
        failures++;
      end
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] measured_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [OUT_W-1:0]  control_output;
  logic                     output_clamped;

  drive_scoreboard sb = new();

  // Idle percentages for each side, switched per phase by the stimulus.
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 73;
  int          settings_applied = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic        hold_off_due = 1'b0;

  positional_pid_controller_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .measured_value (measured_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .control_output (control_output),
    .output_clamped (output_clamped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is asked for. The hold-off
  // lets the pipeline fill so that in_stall has to rise against a busy sender.
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_off_due) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_due = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Results are taken at the rising edge, before the RTL's registers move on.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_drive(control_output, output_clamped);
    end
  end

  // Called at a falling edge with nothing in flight; ends at a falling edge.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.configure(idx, data);
    @(negedge clk);
  endtask

  // Limits travel with random upper bits; only the low ten bits are meant to count.
  task automatic apply_settings(input logic [DATA_W-1:0] kp, ki, kd, target,
                                input logic [LIM_W-1:0] int_lim, out_lim);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_SETPOINT, target);
    write_reg(REG_INT_LIM, {junk[DATA_W-1:LIM_W], int_lim});
    write_reg(REG_OUT_LIM, {~junk[DATA_W-1:LIM_W], out_lim});
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // One sample request; valid stays up after acceptance so back-to-back requests
  // need no second assignment in the same step.
  task automatic send_sample(input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    measured_value <= v;
    do @(posedge clk); while (in_stall);
    sb.take_sample(v);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Signed value spread evenly over plus or minus span.
  function automatic logic [DATA_W-1:0] near_zero(input logic [DATA_W-1:0] span);
    logic [DATA_W-1:0] r;
    r = $urandom_range(0, 2 * span);
    return r - span;
  endfunction

  // Mostly modest gains so that outputs often land inside the clamp.
  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return '0;
      3: return $urandom;
      default: return near_zero(32'h0004_0000);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return LIM_W'(1000);
      2: return LIM_W'(1023);
      3: return LIM_W'(20);
      default: return LIM_W'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_target();
    case ($urandom_range(5))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return $urandom;
      default: return near_zero(32'h03E8_0000);
    endcase
  endfunction

  // Mostly samples close to the setpoint so the integral swings both ways.
  function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] target);
    case ($urandom_range(9))
      0: return $urandom;
      1: return FIX_MAX;
      2: return FIX_MIN;
      default: return target + near_zero(32'h0040_0000);
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero gains, so the drive is zero.
    send_sample(FIX_ONE);
    send_sample(FIX_MIN);
    wait_drained();

    // Output clamp at 20 units: exactly on the limit is not flagged, one LSB past is.
    apply_settings(FIX_ONE, '0, '0, '0, LIM_W'(1000), LIM_W'(20));
    send_sample(-(32'd20 << FRAC_BITS));
    send_sample(-(32'd20 << FRAC_BITS) - 1);
    send_sample(32'd20 << FRAC_BITS);
    send_sample((32'd20 << FRAC_BITS) + 1);
    wait_drained();

    // Extreme gains and limits above 1000; error saturates upward, error change both ways.
    apply_settings(FIX_MAX, FIX_MIN, FIX_MIN, '0, LIM_W'(1023), LIM_W'(1023));
    send_sample(FIX_MIN);
    send_sample(FIX_MAX);
    send_sample(FIX_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(32'd1);
    wait_drained();

    // Zero limits: integral and output pinned at 0, flag only when the raw sum is nonzero.
    apply_settings(FIX_ONE, FIX_ONE, FIX_ONE, FIX_MAX, '0, '0);
    send_sample(FIX_MAX);
    send_sample('0);
    send_sample('1);
    send_sample(FIX_MAX);
    send_sample(FIX_MAX);
    wait_drained();

    // Fractional and negative gains, so the truncating shifts must floor.
    apply_settings(-32'sh8000, 32'h0001_8000, 32'd3, -32'sd12345,
                   LIM_W'(7), LIM_W'(1000));
    send_sample(32'd1);
    send_sample('1);
    send_sample(32'd3);
    send_sample(-32'sd3);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    wait_drained();

    // Random settings per phase; idling pattern follows the phase number.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 73;
      end else if (ph < 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      target = pick_target();
      apply_settings(pick_gain(), pick_gain(), pick_gain(), target,
                     pick_limit(), pick_limit());
      if (ph == 1 || ph == 6) hold_off_due = 1'b1;
      repeat (PHASE_SAMPLES) send_sample(pick_sample(target));
      wait_drained();
    end

    $display("covered %0d samples under %0d register settings, incl. extreme gains and limits",
             sb.samples, settings_applied);
    $display("%0d results checked, %0d of them clamped", sb.checked, sb.clamp_count);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("timed out with %0d results outstanding", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule
